// ===== rtl/mpo_pkg.sv =====
// Shared types, constants and codes of the mitred polyline offset block.
package mpo_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int IDX_W = $clog2(MAX_POINTS);

  localparam int PT_W = 24;
  localparam int DIST_W = 21;
  localparam int IDX_OUT_W = 12;
  localparam int MIN_DEN_W = 15;
  localparam logic [MIN_DEN_W-1:0] MIN_DEN_RESET = 15'd3277;

  localparam int UNIT_W = 16;
  localparam int VEC_W = 25;
  localparam int SQ_W = 62;
  localparam int LEN_W = 31;
  localparam int NUM_W = 46;
  localparam int QUO_W = 48;
  localparam int DEN_W = 16;
  localparam int DIV_N_W = 47;
  localparam int DIV_D_W = 32;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_VEC,
    OP_SQ,
    OP_SQRT_GO,
    OP_SQRT_WAIT,
    OP_DIV_GO,
    OP_DIV_WAIT,
    OP_PROJ_MUL,
    OP_PROJ_SUM,
    OP_MOVE_MUL,
    OP_PUSH,
    OP_UPDATE
  } op_t;

  typedef enum logic [1:0] {VS_IN, VS_OUT, VS_MITRE} vsel_t;
  typedef enum logic [1:0] {TS_A, TS_B, TS_C} tsel_t;
  typedef enum logic [1:0] {DS_UX, DS_UY, DS_MX, DS_MY} dsel_t;
  typedef enum logic [2:0] {UPD_NONE, UPD_FIRST, UPD_SECOND, UPD_SHIFT, UPD_END} upd_t;
  typedef enum logic [1:0] {SRC_RESULT, SRC_FIRST, SRC_INPUT} src_t;
  typedef enum logic [1:0] {IX_PREV, IX_CUR, IX_ZERO, IX_ONE} isel_t;
  typedef enum logic [1:0] {PH_EMPTY, PH_ONE, PH_TWO} phase_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SHORT_ZERO,
    ST_SHORT_FIRST,
    ST_SHORT_ONE,
    ST_LOAD,
    ST_VEC,
    ST_SQ,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_UX_GO,
    ST_UX_WAIT,
    ST_UY_GO,
    ST_UY_WAIT,
    ST_PROJ_MUL,
    ST_PROJ_SUM,
    ST_MOVE_MUL,
    ST_MX_GO,
    ST_MX_WAIT,
    ST_MY_GO,
    ST_MY_WAIT,
    ST_PUSH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    op_t op;
    vsel_t vsel;
    tsel_t tsel;
    dsel_t dsel;
    upd_t upd;
    src_t src;
    isel_t isel;
    logic short_loop;
    logic last_result;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic vec_zero;
    logic out_free;
    logic in_last;
  } stat_t;

endpackage

// ===== rtl/mpo_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module mpo_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [mpo_pkg::SQ_W-1:0] radicand,
  output logic                     done,
  output logic [mpo_pkg::LEN_W-1:0] root
);
  import mpo_pkg::*;

  logic [SQ_W-1:0] n;
  logic [SQ_W-1:0] r;
  logic [SQ_W-1:0] b;
  logic [4:0] cnt;
  logic busy;
  logic [SQ_W-1:0] trial;
  logic ge;

  assign trial = r + b;
  assign ge = (n >= trial);
  assign root = r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= radicand;
      r <= '0;
      b <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy) begin
      if (ge) begin
        n <= n - trial;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

// ===== rtl/mpo_div.sv =====
// Iterative rounding divider, one quotient bit per cycle, halves away from zero.
module mpo_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [mpo_pkg::NUM_W-1:0] num,
  input  logic [mpo_pkg::LEN_W-1:0]        den,
  output logic                             done,
  output logic signed [mpo_pkg::QUO_W-1:0] quo
);
  import mpo_pkg::*;

  logic [DIV_N_W-1:0] nq;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] dd;
  logic neg;
  logic busy;
  logic [5:0] cnt;
  logic [NUM_W-1:0] mag;
  logic [DIV_D_W:0] trial;
  logic ge;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem, nq[DIV_N_W-1]};
  assign ge = (trial >= {1'b0, dd});
  assign quo = neg ? -QUO_W'({1'b0, nq}) : QUO_W'({1'b0, nq});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq <= {mag, 1'b0} + DIV_N_W'(den);
      dd <= {den, 1'b0};
      rem <= '0;
      neg <= num[NUM_W-1];
    end else if (busy) begin
      rem <= ge ? DIV_D_W'(trial - {1'b0, dd}) : trial[DIV_D_W-1:0];
      nq <= {nq[DIV_N_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/mpo_datapath.sv =====
// Datapath: point history, mitre arithmetic on shared units and the result register.
module mpo_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  mpo_pkg::cmd_t                      cmd,
  output mpo_pkg::stat_t                     stat,
  input  logic [mpo_pkg::MIN_DEN_W-1:0]      min_den,
  input  logic signed [mpo_pkg::PT_W-1:0]    in_x,
  input  logic signed [mpo_pkg::PT_W-1:0]    in_y,
  input  logic signed [mpo_pkg::DIST_W-1:0]  in_dist,
  input  logic                               in_last_point,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mpo_pkg::IDX_OUT_W-1:0]      out_idx,
  output logic signed [mpo_pkg::PT_W-1:0]    out_x,
  output logic signed [mpo_pkg::PT_W-1:0]    out_y,
  output logic                               out_short,
  output logic                               out_last
);
  import mpo_pkg::*;

  logic signed [PT_W-1:0] px, py, first_x, first_y, second_x, second_y;
  logic signed [PT_W-1:0] older_x, older_y, newer_x, newer_y;
  logic signed [DIST_W-1:0] pd, first_d, newer_d;
  logic plast;
  logic [IDX_W-1:0] points;
  logic [IDX_W-1:0] points_inc;

  logic signed [PT_W-1:0] prv_x, prv_y, cur_x, cur_y, nxt_x, nxt_y;
  logic signed [DIST_W-1:0] move_d;
  logic signed [VEC_W-1:0] vx, vy;
  logic [SQ_W-1:0] sqsum;
  logic [LEN_W-1:0] len;
  logic signed [UNIT_W-1:0] ix, iy, ox, oy, mx, my;
  logic signed [2*UNIT_W:0] pa, pb;
  logic [DEN_W-1:0] den;
  logic signed [DIST_W+UNIT_W-1:0] pmx, pmy;
  logic signed [QUO_W-1:0] rx, ry;

  logic signed [2*VEC_W-1:0] sqx, sqy;
  logic [2*VEC_W:0] sqs;
  logic signed [UNIT_W:0] noy;
  logic signed [2*UNIT_W+1:0] psum;
  logic [2*UNIT_W+1:0] pmag;
  logic [2*UNIT_W+1:0] pq;
  logic [DEN_W-1:0] den0;

  logic sqrt_done, div_done;
  logic [LEN_W-1:0] root;
  logic signed [QUO_W-1:0] quo;
  logic signed [NUM_W-1:0] div_num;
  logic [LEN_W-1:0] div_den;

  logic out_free;
  logic signed [PT_W:0] sx, sy;
  logic signed [QUO_W:0] sum_x, sum_y;
  logic signed [PT_W-1:0] res_x, res_y;
  logic [IDX_W-1:0] idx_sel;
  logic [31:0] idx_wide;

  function automatic logic signed [PT_W-1:0] sat24(input logic signed [QUO_W:0] v);
    if (v > (QUO_W+1)'(8388607)) begin
      return PT_W'(8388607);
    end else if (v < -(QUO_W+1)'(8388608)) begin
      return PT_W'(-8388608);
    end else begin
      return v[PT_W-1:0];
    end
  endfunction

  assign points_inc = (points == IDX_W'(MAX_POINTS - 1)) ? '0 : points + IDX_W'(1);
  assign out_free = !out_valid || out_ready;

  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done = div_done;
  assign stat.vec_zero = (vx == '0) && (vy == '0);
  assign stat.out_free = out_free;
  assign stat.in_last = plast;

  assign sqx = vx * vx;
  assign sqy = vy * vy;
  assign sqs = (2*VEC_W+1)'(sqx) + (2*VEC_W+1)'(sqy);

  assign noy = -(UNIT_W+1)'(oy);
  assign psum = (2*UNIT_W+2)'(pa) + (2*UNIT_W+2)'(pb);
  assign pmag = psum[2*UNIT_W+1] ? (2*UNIT_W+2)'(-psum) : (2*UNIT_W+2)'(psum);
  assign pq = (pmag + (2*UNIT_W+2)'(8192)) >> 14;
  assign den0 = (min_den == '0) ? DEN_W'(1) : DEN_W'(min_den);

  always_comb begin
    case (cmd.dsel)
      DS_UX: begin
        div_num = NUM_W'(vx) <<< 20;
        div_den = len;
      end
      DS_UY: begin
        div_num = NUM_W'(vy) <<< 20;
        div_den = len;
      end
      DS_MX: begin
        div_num = NUM_W'(pmx);
        div_den = LEN_W'(den);
      end
      default: begin
        div_num = NUM_W'(pmy);
        div_den = LEN_W'(den);
      end
    endcase
  end

  mpo_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_SQRT_GO),
    .radicand (sqsum),
    .done     (sqrt_done),
    .root     (root)
  );

  mpo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIV_GO),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign sum_x = (QUO_W+1)'(cur_x) + (QUO_W+1)'(rx);
  assign sum_y = (QUO_W+1)'(cur_y) + (QUO_W+1)'(ry);
  assign res_x = sat24(sum_x);
  assign res_y = sat24(sum_y);
  assign sx = (PT_W+1)'(res_x);
  assign sy = (PT_W+1)'(res_y);

  always_comb begin
    case (cmd.isel)
      IX_PREV: idx_sel = (points == '0) ? IDX_W'(MAX_POINTS - 1) : points - IDX_W'(1);
      IX_CUR:  idx_sel = points;
      IX_ONE:  idx_sel = IDX_W'(1);
      default: idx_sel = '0;
    endcase
    idx_wide = 32'(idx_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x <= '0;
      first_y <= '0;
      second_x <= '0;
      second_y <= '0;
      older_x <= '0;
      older_y <= '0;
      newer_x <= '0;
      newer_y <= '0;
      first_d <= '0;
      newer_d <= '0;
      points <= '0;
    end else if (cmd.op == OP_UPDATE) begin
      case (cmd.upd)
        UPD_FIRST: begin
          first_x <= px;
          first_y <= py;
          first_d <= pd;
          newer_x <= px;
          newer_y <= py;
          newer_d <= pd;
          points <= plast ? '0 : IDX_W'(1);
        end
        UPD_SECOND: begin
          second_x <= px;
          second_y <= py;
          if (plast) begin
            points <= '0;
          end else begin
            older_x <= newer_x;
            older_y <= newer_y;
            newer_x <= px;
            newer_y <= py;
            newer_d <= pd;
            points <= points_inc;
          end
        end
        UPD_SHIFT: begin
          older_x <= newer_x;
          older_y <= newer_y;
          newer_x <= px;
          newer_y <= py;
          newer_d <= pd;
          points <= points_inc;
        end
        UPD_END: begin
          points <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        px <= in_x;
        py <= in_y;
        pd <= in_dist;
        plast <= in_last_point;
      end
      OP_LOAD: begin
        case (cmd.tsel)
          TS_A: begin
            prv_x <= older_x;
            prv_y <= older_y;
            cur_x <= newer_x;
            cur_y <= newer_y;
            nxt_x <= px;
            nxt_y <= py;
            move_d <= newer_d;
          end
          TS_B: begin
            prv_x <= newer_x;
            prv_y <= newer_y;
            cur_x <= px;
            cur_y <= py;
            nxt_x <= first_x;
            nxt_y <= first_y;
            move_d <= pd;
          end
          default: begin
            prv_x <= px;
            prv_y <= py;
            cur_x <= first_x;
            cur_y <= first_y;
            nxt_x <= second_x;
            nxt_y <= second_y;
            move_d <= first_d;
          end
        endcase
      end
      OP_VEC: begin
        case (cmd.vsel)
          VS_IN: begin
            vx <= VEC_W'(cur_x) - VEC_W'(prv_x);
            vy <= VEC_W'(cur_y) - VEC_W'(prv_y);
            ix <= '0;
            iy <= '0;
          end
          VS_OUT: begin
            vx <= VEC_W'(nxt_x) - VEC_W'(cur_x);
            vy <= VEC_W'(nxt_y) - VEC_W'(cur_y);
            ox <= '0;
            oy <= '0;
          end
          default: begin
            vx <= -VEC_W'(iy) - VEC_W'(oy);
            vy <= VEC_W'(ix) + VEC_W'(ox);
            mx <= '0;
            my <= '0;
          end
        endcase
      end
      OP_SQ: begin
        sqsum <= {sqs[2*VEC_W-1:0], 12'b0};
      end
      OP_SQRT_WAIT: begin
        if (sqrt_done) begin
          len <= root;
        end
      end
      OP_DIV_WAIT: begin
        if (div_done) begin
          case (cmd.dsel)
            DS_UX: begin
              case (cmd.vsel)
                VS_IN:   ix <= quo[UNIT_W-1:0];
                VS_OUT:  ox <= quo[UNIT_W-1:0];
                default: mx <= quo[UNIT_W-1:0];
              endcase
            end
            DS_UY: begin
              case (cmd.vsel)
                VS_IN:   iy <= quo[UNIT_W-1:0];
                VS_OUT:  oy <= quo[UNIT_W-1:0];
                default: my <= quo[UNIT_W-1:0];
              endcase
            end
            DS_MX:   rx <= quo;
            default: ry <= quo;
          endcase
        end
      end
      OP_PROJ_MUL: begin
        pa <= (2*UNIT_W+1)'(mx) * (2*UNIT_W+1)'(noy);
        pb <= (2*UNIT_W+1)'(my) * (2*UNIT_W+1)'(ox);
      end
      OP_PROJ_SUM: begin
        if (!psum[2*UNIT_W+1] && (pq > (2*UNIT_W+2)'(den0))) begin
          den <= pq[DEN_W-1:0];
        end else begin
          den <= den0;
        end
      end
      OP_MOVE_MUL: begin
        pmx <= (DIST_W+UNIT_W)'(move_d) * (DIST_W+UNIT_W)'(mx);
        pmy <= (DIST_W+UNIT_W)'(move_d) * (DIST_W+UNIT_W)'(my);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.op == OP_PUSH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == OP_PUSH) && out_free) begin
      out_idx <= idx_wide[IDX_OUT_W-1:0];
      out_short <= cmd.short_loop;
      out_last <= cmd.last_result;
      case (cmd.src)
        SRC_RESULT: begin
          out_x <= sx[PT_W-1:0];
          out_y <= sy[PT_W-1:0];
        end
        SRC_FIRST: begin
          out_x <= first_x;
          out_y <= first_y;
        end
        default: begin
          out_x <= px;
          out_y <= py;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mpo_ctrl.sv =====
// Controller: sequences loop bookkeeping and the steps of each mitred result.
module mpo_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mpo_pkg::stat_t stat,
  output mpo_pkg::cmd_t  cmd
);
  import mpo_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;
  tsel_t rsel, rsel_next;
  vsel_t vsel, vsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_EMPTY;
      rsel <= TS_A;
      vsel <= VS_IN;
    end else begin
      state <= state_next;
      phase <= phase_next;
      rsel <= rsel_next;
      vsel <= vsel_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    rsel_next = rsel;
    vsel_next = vsel;
    in_ready = 1'b0;
    cmd = '0;
    cmd.vsel = vsel;
    cmd.tsel = rsel;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_CAPTURE;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (phase)
          PH_EMPTY: begin
            cmd.op = OP_UPDATE;
            cmd.upd = UPD_FIRST;
            if (stat.in_last) begin
              state_next = ST_SHORT_ZERO;
            end else begin
              phase_next = PH_ONE;
              state_next = ST_IDLE;
            end
          end
          PH_ONE: begin
            cmd.op = OP_UPDATE;
            cmd.upd = UPD_SECOND;
            if (stat.in_last) begin
              phase_next = PH_EMPTY;
              state_next = ST_SHORT_FIRST;
            end else begin
              phase_next = PH_TWO;
              state_next = ST_IDLE;
            end
          end
          default: begin
            rsel_next = TS_A;
            state_next = ST_LOAD;
          end
        endcase
      end
      ST_SHORT_ZERO: begin
        cmd.op = OP_PUSH;
        cmd.src = SRC_INPUT;
        cmd.isel = IX_ZERO;
        cmd.short_loop = 1'b1;
        cmd.last_result = 1'b1;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SHORT_FIRST: begin
        cmd.op = OP_PUSH;
        cmd.src = SRC_FIRST;
        cmd.isel = IX_ZERO;
        cmd.short_loop = 1'b1;
        if (stat.out_free) begin
          state_next = ST_SHORT_ONE;
        end
      end
      ST_SHORT_ONE: begin
        cmd.op = OP_PUSH;
        cmd.src = SRC_INPUT;
        cmd.isel = IX_ONE;
        cmd.short_loop = 1'b1;
        cmd.last_result = 1'b1;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd.op = OP_LOAD;
        vsel_next = VS_IN;
        state_next = ST_VEC;
      end
      ST_VEC: begin
        cmd.op = OP_VEC;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        if (stat.vec_zero) begin
          case (vsel)
            VS_IN: begin
              vsel_next = VS_OUT;
              state_next = ST_VEC;
            end
            VS_OUT: begin
              vsel_next = VS_MITRE;
              state_next = ST_VEC;
            end
            default: state_next = ST_PROJ_MUL;
          endcase
        end else begin
          cmd.op = OP_SQ;
          state_next = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO: begin
        cmd.op = OP_SQRT_GO;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        cmd.op = OP_SQRT_WAIT;
        if (stat.sqrt_done) begin
          state_next = ST_UX_GO;
        end
      end
      ST_UX_GO: begin
        cmd.op = OP_DIV_GO;
        cmd.dsel = DS_UX;
        state_next = ST_UX_WAIT;
      end
      ST_UX_WAIT: begin
        cmd.op = OP_DIV_WAIT;
        cmd.dsel = DS_UX;
        if (stat.div_done) begin
          state_next = ST_UY_GO;
        end
      end
      ST_UY_GO: begin
        cmd.op = OP_DIV_GO;
        cmd.dsel = DS_UY;
        state_next = ST_UY_WAIT;
      end
      ST_UY_WAIT: begin
        cmd.op = OP_DIV_WAIT;
        cmd.dsel = DS_UY;
        if (stat.div_done) begin
          case (vsel)
            VS_IN: begin
              vsel_next = VS_OUT;
              state_next = ST_VEC;
            end
            VS_OUT: begin
              vsel_next = VS_MITRE;
              state_next = ST_VEC;
            end
            default: state_next = ST_PROJ_MUL;
          endcase
        end
      end
      ST_PROJ_MUL: begin
        cmd.op = OP_PROJ_MUL;
        state_next = ST_PROJ_SUM;
      end
      ST_PROJ_SUM: begin
        cmd.op = OP_PROJ_SUM;
        state_next = ST_MOVE_MUL;
      end
      ST_MOVE_MUL: begin
        cmd.op = OP_MOVE_MUL;
        state_next = ST_MX_GO;
      end
      ST_MX_GO: begin
        cmd.op = OP_DIV_GO;
        cmd.dsel = DS_MX;
        state_next = ST_MX_WAIT;
      end
      ST_MX_WAIT: begin
        cmd.op = OP_DIV_WAIT;
        cmd.dsel = DS_MX;
        if (stat.div_done) begin
          state_next = ST_MY_GO;
        end
      end
      ST_MY_GO: begin
        cmd.op = OP_DIV_GO;
        cmd.dsel = DS_MY;
        state_next = ST_MY_WAIT;
      end
      ST_MY_WAIT: begin
        cmd.op = OP_DIV_WAIT;
        cmd.dsel = DS_MY;
        if (stat.div_done) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.op = OP_PUSH;
        cmd.src = SRC_RESULT;
        case (rsel)
          TS_A:    cmd.isel = IX_PREV;
          TS_B:    cmd.isel = IX_CUR;
          default: cmd.isel = IX_ZERO;
        endcase
        cmd.last_result = (rsel == TS_C);
        if (stat.out_free) begin
          case (rsel)
            TS_A: begin
              if (stat.in_last) begin
                rsel_next = TS_B;
                state_next = ST_LOAD;
              end else begin
                state_next = ST_UPDATE;
              end
            end
            TS_B: begin
              rsel_next = TS_C;
              state_next = ST_LOAD;
            end
            default: begin
              state_next = ST_UPDATE;
            end
          endcase
        end
      end
      ST_UPDATE: begin
        cmd.op = OP_UPDATE;
        if (rsel == TS_C) begin
          cmd.upd = UPD_END;
          phase_next = PH_EMPTY;
        end else begin
          cmd.upd = UPD_SHIFT;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mitred_polyline_offset.sv =====
// Top level of the mitred polyline offset block with its register port.
//
// Points of a closed polyline arrive one request at a time on the slave stream,
// each with its own offset distance; tlast marks the last point of the loop.
// Each moved point leaves on the master stream one point late; the request that
// carries the last point produces the results for the final and first points
// too, the final result of the loop carrying tlast. Loops of one or two points
// come back unmoved with tuser (short loop) set.
// One mitred result takes three normalizations, each a 31-step square root and
// two 47-step divisions, then two more divisions, all on one shared square root
// unit and one shared divider. Only one point is in work at a time.
// The result waits in an output register; while the receiver stalls, the block
// still takes the next point and stops only when a further result is ready.
// Reset empties the loop history and sets min_denominator to 0.2 in Q1.14.
// The user must write the register only while no request is in work; the block does not enforce it.
module mitred_polyline_offset (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x[23:0], point_y[47:24], offset_distance[68:48], zero fill
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_index[11:0], offset_x[35:12], offset_y[59:36], zero fill
  output logic [63:0] m_axis_tdata,
  // short_loop[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpo_pkg::*;

  logic [MIN_DEN_W-1:0] min_den;
  cmd_t cmd;
  stat_t stat;
  logic [IDX_OUT_W-1:0] out_idx;
  logic signed [PT_W-1:0] out_x, out_y;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(min_den);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_den <= MIN_DEN_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      min_den <= pwdata[MIN_DEN_W-1:0];
    end
  end

  mpo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpo_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .min_den       (min_den),
    .in_x          (s_axis_tdata[23:0]),
    .in_y          (s_axis_tdata[47:24]),
    .in_dist       (s_axis_tdata[68:48]),
    .in_last_point (s_axis_tlast),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_idx       (out_idx),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_short     (m_axis_tuser),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_y, out_x, out_idx};

endmodule
